/* src/u2cb_pkg.sv */
// ----------------------------------------------------------------------------
// u2cb_pkg
// Types, constants and the pair-mapping function for the UTF-8 to
// single-byte Cyrillic decoder.
// ----------------------------------------------------------------------------
package u2cb_pkg;

  localparam int unsigned ByteW = 8;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEAD = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  localparam logic [ByteW-1:0] LEAD_D0      = 8'hD0;
  localparam logic [ByteW-1:0] LEAD_D1      = 8'hD1;
  localparam logic [ByteW-1:0] LEAD_D2      = 8'hD2;
  localparam logic [ByteW-1:0] OFS_D0       = 8'h30;
  localparam logic [ByteW-1:0] OFS_D1       = 8'h70;
  localparam logic [ByteW-1:0] CODE_IO_UP   = 8'hC5;
  localparam logic [ByteW-1:0] CODE_IO_LO   = 8'hE5;
  localparam logic [ByteW-1:0] CODE_GHE_UP  = 8'hC3;
  localparam logic [ByteW-1:0] CODE_GHE_LO  = 8'hE3;
  localparam logic [ByteW-1:0] CODE_I_UP    = 8'h49;
  localparam logic [ByteW-1:0] CODE_I_LO    = 8'h69;
  localparam logic [ByteW-1:0] CODE_UNKNOWN = 8'h3F;
  localparam logic [1:0]       CONT_TAG     = 2'b10;

  typedef struct packed {
    logic             known;
    logic [ByteW-1:0] code;
  } map_t;

  function automatic map_t map_pair(input logic [ByteW-1:0] lead,
                                    input logic [ByteW-1:0] d);
    map_t r;
    r.known = 1'b1;
    r.code  = CODE_UNKNOWN;
    if (lead == LEAD_D0) begin
      if (d >= 8'h90 && d <= 8'hBF)      r.code = d + OFS_D0;
      else if (d == 8'h81 || d == 8'h84) r.code = CODE_IO_UP;
      else if (d == 8'h86 || d == 8'h87) r.code = CODE_I_UP;
      else                               r.known = 1'b0;
    end else if (lead == LEAD_D1) begin
      if (d >= 8'h80 && d <= 8'h8F)      r.code = d + OFS_D1;
      else if (d == 8'h91 || d == 8'h94) r.code = CODE_IO_LO;
      else if (d == 8'h96 || d == 8'h97) r.code = CODE_I_LO;
      else                               r.known = 1'b0;
    end else if (lead == LEAD_D2) begin
      if (d == 8'h90)                    r.code = CODE_GHE_UP;
      else if (d == 8'h91)               r.code = CODE_GHE_LO;
      else                               r.known = 1'b0;
    end else begin
      r.known = 1'b0;
    end
    return r;
  endfunction

endpackage

/* src/utf8_to_cyrillic_byte_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_cyrillic_byte_decoder
// Turns a UTF-8 byte stream into single-byte Cyrillic display codes.
// ----------------------------------------------------------------------------
// One byte enters per cycle and, if it yields a code, leaves through an
// input register, one level of compare-and-add logic against the
// held lead byte, and an output register. Throughput is one byte per cycle
// while the output side keeps taking; backpressure reaches the input ready
// in the same cycle. ASCII passes through, two-byte Cyrillic pairs map to
// their code, an unknown pair gives '?' and drops the continuation bytes
// after it, and a lead byte flagged as last gives '?'. tlast closes a
// string and returns the decoder to its idle phase.
module utf8_to_cyrillic_byte_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // end_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] display_code
);
  import u2cb_pkg::*;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             in_last;

  phase_t           phase, phase_next;
  logic [ByteW-1:0] held_lead, held_lead_next;

  logic             out_valid;
  logic [ByteW-1:0] out_data;

  logic             process;
  logic             produce;
  logic [ByteW-1:0] code;
  map_t             pair;

  assign process       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || process;
  assign pair          = map_pair(held_lead, in_byte);

  always_comb begin
    produce        = 1'b0;
    code           = in_byte;
    phase_next     = phase;
    held_lead_next = held_lead;
    unique case (phase)
      PH_LEAD: begin
        produce    = 1'b1;
        code       = pair.code;
        phase_next = pair.known ? PH_IDLE : PH_SKIP;
      end
      default: begin
        if (phase == PH_SKIP && in_byte[7:6] == CONT_TAG) begin
          produce = 1'b0;
        end else if (!in_byte[7]) begin
          produce    = 1'b1;
          code       = in_byte;
          phase_next = PH_IDLE;
        end else begin
          held_lead_next = in_byte;
          if (in_last) begin
            produce = 1'b1;
            code    = CODE_UNKNOWN;
          end else begin
            phase_next = PH_LEAD;
          end
        end
      end
    endcase
    if (in_last) phase_next = PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_IDLE;
      held_lead <= '0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (process) begin
        phase     <= phase_next;
        held_lead <= held_lead_next;
      end
      if (process && produce) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (process && produce) out_data <= code;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    process && in_last |=> phase == PH_IDLE)
    else $error("phase not idle after end of text");

  a_pair_out: assert property (@(posedge clk) disable iff (rst)
    process && phase == PH_LEAD |=> m_axis_tvalid)
    else $error("pair produced no code");

  a_ascii_pass: assert property (@(posedge clk) disable iff (rst)
    process && phase != PH_LEAD && !in_byte[7]
      |=> m_axis_tvalid && m_axis_tdata == $past(in_byte))
    else $error("ascii byte not passed through");

endmodule

/* test/tb_utf8_to_cyrillic_byte_decoder.sv */
// ----------------------------------------------------------------------------
// tb_utf8_to_cyrillic_byte_decoder
// Streams UTF-8 strings through the decoder and checks every display code.
// ----------------------------------------------------------------------------
// A behavioral decoder tracks the phase and held lead byte of the block.
// Each accepted input item updates it and queues the code it should yield;
// each accepted output item is compared with the oldest queued code.
// Directed strings cover ASCII, mapped pairs and malformed sequences, then
// random text runs under three idle mixes on the input and output sides.
module tb_utf8_to_cyrillic_byte_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import u2cb_pkg::*;

  localparam int StallLimit = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  int src_idle_pct = 19;
  int snk_idle_pct = 60;
  int mismatches = 0;
  int stall_cycles = 0;

  phase_t     text_phase = PH_IDLE;
  logic [7:0] lead_hold = '0;
  logic [7:0] code_q[$];
  logic [7:0] text_q[$];

  utf8_to_cyrillic_byte_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  function automatic logic [7:0] cp1251_of_pair(input logic [7:0] lead,
                                                input logic [7:0] trail,
                                                output bit hit);
    hit = 1'b1;
    if (lead == LEAD_D0) begin
      if (trail >= 8'h90 && trail <= 8'hBF) return trail + OFS_D0;
      if (trail == 8'h81 || trail == 8'h84) return CODE_IO_UP;
      if (trail == 8'h86 || trail == 8'h87) return CODE_I_UP;
    end else if (lead == LEAD_D1) begin
      if (trail >= 8'h80 && trail <= 8'h8F) return trail + OFS_D1;
      if (trail == 8'h91 || trail == 8'h94) return CODE_IO_LO;
      if (trail == 8'h96 || trail == 8'h97) return CODE_I_LO;
    end else if (lead == LEAD_D2) begin
      if (trail == 8'h90) return CODE_GHE_UP;
      if (trail == 8'h91) return CODE_GHE_LO;
    end
    hit = 1'b0;
    return CODE_UNKNOWN;
  endfunction

  function automatic void decode_text_byte(input logic [7:0] b, input bit last);
    bit         hit;
    logic [7:0] code;
    if (text_phase == PH_LEAD) begin
      code = cp1251_of_pair(lead_hold, b, hit);
      code_q.push_back(code);
      text_phase = hit ? PH_IDLE : PH_SKIP;
    end else if (text_phase == PH_SKIP && b[7:6] == CONT_TAG) begin
      // continuation byte after an unknown pair: dropped
    end else if (!b[7]) begin
      code_q.push_back(b);
      text_phase = PH_IDLE;
    end else begin
      lead_hold = b;
      if (last) code_q.push_back(CODE_UNKNOWN);
      else      text_phase = PH_LEAD;
    end
    if (last) text_phase = PH_IDLE;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        decode_text_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (code_q.size() == 0) begin
          $display("%0t: display_code expected none, actual %02h", $time, m_axis_tdata);
          mismatches++;
        end else if (code_q[0] !== m_axis_tdata) begin
          $display("%0t: display_code expected %02h, actual %02h",
                   $time, code_q[0], m_axis_tdata);
          mismatches++;
          void'(code_q.pop_front());
        end else begin
          void'(code_q.pop_front());
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StallLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // hold off the input until every queued code has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (code_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_random_char();
    logic [7:0] d0_extra[4] = '{8'h81, 8'h84, 8'h86, 8'h87};
    logic [7:0] d1_extra[4] = '{8'h91, 8'h94, 8'h96, 8'h97};
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      text_q.push_back(8'($urandom_range(8'h01, 8'h7F)));
    end else if (pick < 75) begin
      case ($urandom_range(0, 2))
        0: begin
          text_q.push_back(LEAD_D0);
          if ($urandom_range(0, 3) == 0)
            text_q.push_back(d0_extra[2'($urandom_range(0, 3))]);
          else
            text_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
        end
        1: begin
          text_q.push_back(LEAD_D1);
          if ($urandom_range(0, 3) == 0)
            text_q.push_back(d1_extra[2'($urandom_range(0, 3))]);
          else
            text_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
        end
        default: begin
          text_q.push_back(LEAD_D2);
          text_q.push_back(8'($urandom_range(8'h90, 8'h91)));
        end
      endcase
    end else if (pick < 88) begin
      // random two-byte pair, mostly unknown, then up to three continuation bytes, dropped after an unknown pair
      text_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
      text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else begin
      text_q.push_back(8'($urandom_range(8'h01, 8'hFF)));
    end
  endtask

  task automatic test_ascii_passthrough();
    text_q = '{8'h01, 8'h7F};
    send_text();
    text_q = '{8'h41};
    send_text();
  endtask

  task automatic test_cyrillic_pairs();
    text_q = '{8'hD0, 8'h90, 8'hD1, 8'h8F, 8'hD0, 8'h84, 8'hD1, 8'h97, 8'hD2, 8'h91};
    send_text();
  endtask

  task automatic test_malformed_sequences();
    text_q = '{8'hD0, 8'h80, 8'hBF, 8'h41};
    send_text();
    text_q = '{8'hD0};
    send_text();
    text_q = '{8'h80, 8'h41};
    send_text();
    text_q = '{8'hFF, 8'hFF, 8'h8A};
    send_text();
    drain();
  endtask

  task automatic test_random_text(input int src_pct, input int snk_pct, input int n_bytes);
    int sent;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_bytes) begin
      text_q = {};
      repeat ($urandom_range(1, 10)) add_random_char();
      if ($urandom_range(0, 9) == 0) text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
      send_text();
      sent += text_q.size();
      if ($urandom_range(0, 19) == 0) drain();
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ascii_passthrough();
    test_cyrillic_pairs();
    test_malformed_sequences();
    test_random_text(19, 60, 200);
    test_random_text(60, 19, 200);
    test_random_text(0, 0, 200);
    repeat (8) @(posedge clk);
    if (code_q.size() != 0) begin
      $display("%0t: %0d display codes expected, none arrived", $time, code_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
